// File: rtl/combined_octave_perlin_noise_2d_top_macros.svh
// Assertion macros shared by the octave noise checker.
`ifndef COMBINED_OCTAVE_PERLIN_NOISE_2D_TOP_MACROS_SVH
`define COMBINED_OCTAVE_PERLIN_NOISE_2D_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define COPN2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen out of reset.
`define COPN2D_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/copn2d_pkg.sv
// Shared constants and types of the octave gradient noise block.
package copn2d_pkg;

  // Default parameter values
  localparam int DEF_MAX_OCTAVES = 8;
  localparam int DEF_FRAC_BITS   = 16;

  // Permutation table organization: 2 sets x 8 octaves x 256 entries
  localparam int TABLES_PER_SET = 8;
  localparam int PERM_AW        = 12;
  localparam int PERM_DW        = 8;

  // Packed 2-bit gradient flags, one pair per hash nibble
  localparam logic [31:0] GRAD_X_FLAGS = 32'h4655_2222;
  localparam logic [31:0] GRAD_Y_FLAGS = 32'h2222_550A;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_OCT_MAIN   = 2'd0;
  localparam logic [1:0] CFG_OCT_OFFSET = 2'd1;

  // Table write request
  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] addr;
    logic [PERM_DW-1:0] data;
  } perm_wr_t;

endpackage

// File: rtl/copn2d_perm_ram.sv
// Permutation table memory: one write port, one registered read port.
module copn2d_perm_ram
  import copn2d_pkg::*;
(
  input  logic               clk_i,
  input  perm_wr_t           wr_i,
  input  logic [PERM_AW-1:0] raddr_i,
  output logic [PERM_DW-1:0] rdata_o
);

  logic [PERM_DW-1:0] mem [0:(1<<PERM_AW)-1];
  logic [PERM_DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/combined_octave_perlin_noise_2d_top.sv
// Octave gradient noise evaluator: sequencer, shared multiplier and table memory.
// An evaluate runs the offset octaves, then the main octaves, before the result
// strobe; each octave makes its table reads on the single RAM port and 11 steps
// on the shared multiplier. A table write does not make the block busy.
// Throughput: one item at a time; busy is high while an evaluate runs.
// Reset: asynchronous active low; octaves_main = 8, octaves_offset = 0; tables
// are not cleared and must be loaded before use. Results cannot be stalled.
module combined_octave_perlin_noise_2d_top
  import copn2d_pkg::*;
#(
  parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic               table_set_i,
  input  logic [2:0]         octave_index_i,
  input  logic [7:0]         entry_index_i,
  input  logic [7:0]         entry_value_i,
  output logic               result_valid_o,
  output logic signed [31:0] noise_value_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [3:0]         cfg_data_i
);

  localparam int W         = FRAC_BITS + 8;
  localparam int GW        = W + 4;
  localparam int OCT_LIMIT = (MAX_OCTAVES < TABLES_PER_SET) ? MAX_OCTAVES : TABLES_PER_SET;
  localparam int AW        = GW + 8 + $clog2(OCT_LIMIT + 1);
  localparam int MA        = (W + 5 > 33) ? W + 5 : 33;
  localparam int BW        = 21;
  localparam int PW        = MA + BW;
  localparam logic [3:0] READ_LAST = 4'd10;
  localparam logic [3:0] MATH_LAST = 4'd10;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OCT  = 4'b0010,
    S_READ = 4'b0100,
    S_MATH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] step_q, step_d, oct_q, oct_d, cnt_q, cnt_d;
  logic       off_q, off_d, valid_q, valid_d;
  logic [3:0] oct_main_q, oct_off_q;

  logic signed [31:0] x_q, y_q, noise_q;
  logic signed [AW-1:0] acc_q;
  logic [W-1:0] fx_q, fy_q;
  logic [7:0] cx_q, cy_q;
  logic [7:0] p0_q, p1_q, ha_q, ha1_q, hb_q, hb1_q, h00_q, h01_q, h10_q, h11_q;
  logic signed [GW-1:0] g00_q, g10_q, g01_q, g11_q, c1_q, c2_q;
  logic [31:0] t2_q;
  logic [15:0] u_q, v_q;
  logic signed [PW-1:0] prod_q;

  logic        eval_go;
  perm_wr_t    wr;
  logic [7:0]  ridx;
  logic [PERM_AW-1:0] raddr;
  logic [PERM_DW-1:0] rdata;

  function automatic logic [3:0] lim_count(input logic [3:0] r);
    return (r > 4'(OCT_LIMIT)) ? 4'(OCT_LIMIT) : r;
  endfunction

  // Gradient dot product from packed flags: factors -1, 0, 1, 2
  function automatic logic signed [GW-1:0] grad_f(input logic [7:0] h,
                                                  input logic signed [W:0] dx,
                                                  input logic signed [W:0] dy);
    logic [1:0] gxc, gyc;
    logic signed [GW-1:0] ex, ey, tx, ty;
    gxc = GRAD_X_FLAGS[{h[3:0], 1'b0} +: 2];
    gyc = GRAD_Y_FLAGS[{h[3:0], 1'b0} +: 2];
    ex  = GW'(dx);
    ey  = GW'(dy);
    unique case (gxc)
      2'd0:    tx = -ex;
      2'd1:    tx = '0;
      2'd2:    tx = ex;
      default: tx = ex <<< 1;
    endcase
    unique case (gyc)
      2'd0:    ty = -ey;
      2'd1:    ty = '0;
      2'd2:    ty = ey;
      default: ty = ey <<< 1;
    endcase
    return tx + ty;
  endfunction

  assign busy    = (state_q != S_IDLE);
  assign eval_go = start && !busy && (command_i == CMD_EVAL);

  // Table write transfer
  always_comb begin
    wr.we   = start && !busy && (command_i == CMD_WRITE);
    wr.addr = {table_set_i, octave_index_i, entry_index_i};
    wr.data = entry_value_i;
  end

  // Read address sequence of one octave
  always_comb begin
    unique case (step_q)
      4'd0:    ridx = cx_q;
      4'd1:    ridx = cx_q + 8'd1;
      4'd2:    ridx = p0_q + cy_q;
      4'd3:    ridx = p0_q + cy_q + 8'd1;
      4'd4:    ridx = p1_q + cy_q;
      4'd5:    ridx = p1_q + cy_q + 8'd1;
      4'd6:    ridx = ha_q;
      4'd7:    ridx = ha1_q;
      4'd8:    ridx = hb_q;
      4'd9:    ridx = hb1_q;
      default: ridx = '0;
    endcase
  end
  assign raddr = {off_q, oct_q[2:0], ridx};

  copn2d_perm_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Octave coordinates: exact shift by 8 - octave
  logic [3:0] shamt;
  logic signed [39:0] sx, sy;
  assign shamt = 4'(TABLES_PER_SET) - oct_q;
  assign sx = 40'(x_q) <<< shamt;
  assign sy = 40'(y_q) <<< shamt;

  // Octave sum scaled and saturated
  logic signed [AW-1:0] acc_sh;
  logic signed [31:0]   acc_sat, xs_sat;
  logic signed [32:0]   xsum;
  assign acc_sh  = acc_q >>> 8;
  assign acc_sat = (acc_sh[AW-1:31] == {(AW-31){acc_sh[AW-1]}}) ? acc_sh[31:0] :
                   (acc_sh[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  assign xsum    = 33'(x_q) + 33'(acc_sat);
  assign xs_sat  = (xsum[32] == xsum[31]) ? xsum[31:0] :
                   (xsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // Gradients at the four corners
  logic signed [W:0] dx0, dx1, dy0, dy1;
  logic signed [GW-1:0] g00, g10, g01, g11;
  assign dx0 = {1'b0, fx_q};
  assign dx1 = {1'b1, fx_q};
  assign dy0 = {1'b0, fy_q};
  assign dy1 = {1'b1, fy_q};
  assign g00 = grad_f(h00_q, dx0, dy0);
  assign g10 = grad_f(h10_q, dx1, dy0);
  assign g01 = grad_f(h01_q, dx0, dy1);
  assign g11 = grad_f(h11_q, dx1, dy1);

  // Fade polynomial 6t^2 - 15t*2^16 + 10*2^32
  logic [15:0] t_u, t_v, t_sel;
  logic [37:0] poly;
  assign t_u   = fx_q[W-1 -: 16];
  assign t_v   = fy_q[W-1 -: 16];
  assign t_sel = (step_q < 4'd3) ? t_u : t_v;
  assign poly  = (38'(t2_q) << 2) + (38'(t2_q) << 1) + (38'd10 << 32)
               - ((38'(t_sel) << 20) - (38'(t_sel) << 16));

  // Lerp terms
  logic signed [GW:0] lin, dif_u0, dif_u1, dif_v, c1_sum, c2_sum, n_sum;
  assign lin    = $signed(prod_q[GW+16:16]);
  assign dif_u0 = (GW+1)'(g10_q) - (GW+1)'(g00_q);
  assign dif_u1 = (GW+1)'(g11_q) - (GW+1)'(g01_q);
  assign dif_v  = (GW+1)'(c2_q) - (GW+1)'(c1_q);
  assign c1_sum = (GW+1)'(g00_q) + lin;
  assign c2_sum = (GW+1)'(g01_q) + lin;
  assign n_sum  = (GW+1)'(c1_q) + lin;

  logic signed [GW-1:0] n_val;
  assign n_val = n_sum[GW-1:0];

  // Shared multiplier operand select
  logic signed [MA-1:0] ma;
  logic signed [BW-1:0] mb;
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_MATH) begin
      unique case (step_q)
        4'd0: begin ma = MA'(t_u);            mb = BW'(t_u); end
        4'd1: begin ma = MA'(prod_q[31:0]);   mb = BW'(t_u); end
        4'd2: begin ma = MA'(prod_q[47:24]);  mb = BW'(poly[35:16]); end
        4'd3: begin ma = MA'(t_v);            mb = BW'(t_v); end
        4'd4: begin ma = MA'(prod_q[31:0]);   mb = BW'(t_v); end
        4'd5: begin ma = MA'(prod_q[47:24]);  mb = BW'(poly[35:16]); end
        4'd6: begin ma = MA'(dif_u0);         mb = BW'(u_q); end
        4'd7: begin ma = MA'(dif_u1);         mb = BW'(u_q); end
        4'd9: begin ma = MA'(dif_v);          mb = BW'(v_q); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    oct_d   = oct_q;
    cnt_d   = cnt_q;
    off_d   = off_q;
    valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (eval_go) begin
          state_d = S_OCT;
          oct_d   = '0;
          cnt_d   = lim_count(oct_off_q);
          off_d   = 1'b1;
        end
      end
      S_OCT: begin
        if (oct_q == cnt_q) begin
          if (off_q) begin
            off_d = 1'b0;
            oct_d = '0;
            cnt_d = lim_count(oct_main_q);
          end else begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_READ;
          step_d  = '0;
        end
      end
      S_READ: begin
        if (step_q == READ_LAST) begin
          state_d = S_MATH;
          step_d  = '0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_MATH: begin
        if (step_q == MATH_LAST) begin
          state_d = S_OCT;
          oct_d   = oct_q + 4'd1;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      oct_q   <= '0;
      cnt_q   <= '0;
      off_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      oct_q   <= oct_d;
      cnt_q   <= cnt_d;
      off_q   <= off_d;
      valid_q <= valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_main_q <= 4'd8;
      oct_off_q  <= 4'd0;
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == CFG_OCT_MAIN) begin
        oct_main_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_OCT_OFFSET) begin
        oct_off_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    unique case (state_q)
      S_IDLE: begin
        if (eval_go) begin
          x_q   <= x_coord_i;
          y_q   <= y_coord_i;
          acc_q <= '0;
        end
      end
      S_OCT: begin
        if (oct_q == cnt_q) begin
          if (off_q) begin
            x_q   <= xs_sat;
            acc_q <= '0;
          end else begin
            noise_q <= acc_sat;
          end
        end else begin
          fx_q <= sx[W-1:0];
          fy_q <= sy[W-1:0];
          cx_q <= sx[W+7:W];
          cy_q <= sy[W+7:W];
        end
      end
      S_READ: begin
        unique case (step_q)
          4'd1:    p0_q  <= rdata;
          4'd2:    p1_q  <= rdata;
          4'd3:    ha_q  <= rdata;
          4'd4:    ha1_q <= rdata;
          4'd5:    hb_q  <= rdata;
          4'd6:    hb1_q <= rdata;
          4'd7:    h00_q <= rdata;
          4'd8:    h01_q <= rdata;
          4'd9:    h10_q <= rdata;
          4'd10:   h11_q <= rdata;
          default: ;
        endcase
      end
      S_MATH: begin
        unique case (step_q)
          4'd0: begin
            g00_q <= g00;
            g10_q <= g10;
            g01_q <= g01;
            g11_q <= g11;
          end
          4'd1:    t2_q <= prod_q[31:0];
          4'd3:    u_q  <= prod_q[39:24];
          4'd4:    t2_q <= prod_q[31:0];
          4'd6:    v_q  <= prod_q[39:24];
          4'd7:    c1_q <= c1_sum[GW-1:0];
          4'd8:    c2_q <= c2_sum[GW-1:0];
          4'd10:   acc_q <= acc_q + (AW'(n_val) <<< oct_q[2:0]);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result_valid_o = valid_q;
  assign noise_value_o  = noise_q;

endmodule

// File: rtl/copn2d_checker.sv
// Port-level checker of the octave noise block and its bind.
`include "combined_octave_perlin_noise_2d_top_macros.svh"

module copn2d_checker
  import copn2d_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic command_i,
  input logic result_valid_o
);

  // Result comes out as the evaluate ends
  `COPN2D_ASSERT(a_res_after_busy, result_valid_o |-> $past(busy), "result without busy")
  // Strobe lasts a single cycle
  `COPN2D_ASSERT(a_res_one_cycle, result_valid_o |=> !result_valid_o, "strobe too long")
  // Table write transfers finish at once
  `COPN2D_ASSERT(a_wr_no_busy, (start && !busy && command_i == CMD_WRITE) |=> !busy,
                 "write made block busy")
  // Evaluate transfers start work
  `COPN2D_ASSERT(a_eval_busy, (start && !busy && command_i == CMD_EVAL) |=> busy,
                 "evaluate did not start")
  // Busy only drops with a result
  `COPN2D_NEVER(a_fall_no_res, $fell(busy) && !result_valid_o, "busy fell without result")

endmodule

bind combined_octave_perlin_noise_2d_top copn2d_checker u_copn2d_checker (.*);
